FILE: hw/rtl/c2es_pkg.sv
// ----------------------------------------------------------------------------
// c2es_pkg: shared constants and helpers for calendar to epoch conversion
// Field widths, stream layouts, the cumulative month table and the
// leap-second instant list.
// ----------------------------------------------------------------------------
package c2es_pkg;

  // Field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int EPOCH_W  = 39;

  // Stream layouts
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 1;

  localparam int YEAR_LSB   = 0;
  localparam int MONTH_LSB  = YEAR_LSB + YEAR_W;
  localparam int DAY_LSB    = MONTH_LSB + MONTH_W;
  localparam int HOUR_LSB   = DAY_LSB + DAY_W;
  localparam int MINUTE_LSB = HOUR_LSB + HOUR_W;
  localparam int SECOND_LSB = MINUTE_LSB + MINUTE_W;

  // Internal widths
  localparam int DCNT_W  = 25;  // signed day count relative to 1970-01-01
  localparam int SOD_W   = 17;  // second of day, unchecked fields included
  localparam int MSTRT_W = 9;   // cumulative days before month
  localparam int LCNT_W  = 3;   // leap seconds passed, 0..5
  localparam int PRD_W   = 26;  // reciprocal products

  // floor(x/25) = (x * RECIP25) >> RECIP_SH for x below 43690
  localparam logic [12:0] RECIP25  = 13'd5243;
  localparam int          RECIP_SH = 17;
  localparam int          DIV25    = 25;

  localparam int SEC_PER_DAY  = 86400;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam int DAYS_PER_YR  = 365;
  localparam int QUAD_OFS     = 399;    // shifts year-1 up by one 400-year cycle
  // cycle correction (-97), days from year 1 to 1970 (-719162), day 1 counts 0 (-1)
  localparam int DAY_BIAS     = -719260;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // Leap-second instants, each at day 1, 08:59:59
  localparam int NUM_LEAP = 5;
  localparam logic [YEAR_W-1:0]  LS_YEAR  [NUM_LEAP] =
    '{14'd2006, 14'd2009, 14'd2012, 14'd2015, 14'd2017};
  localparam logic [MONTH_W-1:0] LS_MONTH [NUM_LEAP] =
    '{4'd1, 4'd1, 4'd7, 4'd7, 4'd1};
  localparam logic [DAY_W-1:0]    LS_DAY    = 5'd1;
  localparam logic [HOUR_W-1:0]   LS_HOUR   = 5'd8;
  localparam logic [MINUTE_W-1:0] LS_MINUTE = 6'd59;
  localparam logic [SECOND_W-1:0] LS_SECOND = 6'd59;

  // Days in the year before the first of the month (non-leap)
  function automatic logic [MSTRT_W-1:0] month_start(input logic [MONTH_W-1:0] mo);
    logic [MSTRT_W-1:0] d;
    unique case (mo)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Count instants strictly before the given time; fields are compared in
  // order since each lower field stays below 100.
  function automatic logic [LCNT_W-1:0] leap_count(
    input logic [YEAR_W-1:0]   yr,
    input logic [MONTH_W-1:0]  mo,
    input logic [DAY_W-1:0]    dy,
    input logic [HOUR_W-1:0]   hr,
    input logic [MINUTE_W-1:0] mi,
    input logic [SECOND_W-1:0] se
  );
    logic              later;
    logic [LCNT_W-1:0] cnt;
    later = (dy > LS_DAY) || ((dy == LS_DAY) && ((hr > LS_HOUR) ||
            ((hr == LS_HOUR) && ((mi > LS_MINUTE) ||
            ((mi == LS_MINUTE) && (se > LS_SECOND))))));
    cnt = '0;
    for (int i = 0; i < NUM_LEAP; i++) begin
      if ((yr > LS_YEAR[i]) || ((yr == LS_YEAR[i]) &&
          ((mo > LS_MONTH[i]) || ((mo == LS_MONTH[i]) && later)))) begin
        cnt = cnt + LCNT_W'(1);
      end
    end
    return cnt;
  endfunction

endpackage

FILE: hw/rtl/calendar_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds: Gregorian date and time to epoch seconds
// Four-stage pipeline that turns a broken-down date and time into seconds
// since 1970-01-01 00:00:00, counting five fixed leap seconds.
// ----------------------------------------------------------------------------
//
//  channel | direction | fields (tdata from bit 0 up / tuser)
//  --------+-----------+--------------------------------------------------
//  in_     | slave     | tdata: year, month, day_of_month, hour, minute, second
//  out_    | master    | tdata: epoch_seconds (39b signed) + pad; tuser: bad_month
//
//  One transfer in and one out per cycle, sustained while out_tready is high.
//  Four register stages, the first loaded at the input transfer edge, with
//  out_tvalid driven by the last: table and reciprocal products, day count,
//  day-to-second multiply, final sum.
//  All four stages advance together; a held output stalls every stage and
//  drops in_tready in the same cycle, so nothing is lost or repeated.
//  Bubbles inside the pipeline are not squeezed out: a held output stalls
//  every stage, whether it holds an item or not.
//  Synchronous active-low reset clears the valid bits only.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // year[13:0], month[17:14], day_of_month[22:18], hour[27:23],
  // minute[33:28], second[39:34]
  input  logic [c2es_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // epoch_seconds[38:0], zero pad [39]
  output logic [c2es_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // bad_month[0]
  output logic [c2es_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import c2es_pkg::*;

  // Unpacked input fields
  logic [YEAR_W-1:0]   yr;
  logic [MONTH_W-1:0]  mo;
  logic [DAY_W-1:0]    dy;
  logic [HOUR_W-1:0]   hr;
  logic [MINUTE_W-1:0] mi;
  logic [SECOND_W-1:0] se;

  assign yr = in_tdata[MONTH_LSB-1:YEAR_LSB];
  assign mo = in_tdata[DAY_LSB-1:MONTH_LSB];
  assign dy = in_tdata[HOUR_LSB-1:DAY_LSB];
  assign hr = in_tdata[MINUTE_LSB-1:HOUR_LSB];
  assign mi = in_tdata[SECOND_LSB-1:MINUTE_LSB];
  assign se = in_tdata[SECOND_LSB+SECOND_W-1:SECOND_LSB];

  // Whole pipeline moves when the output register is free or being drained
  logic adv;
  logic out_valid_r;

  assign adv       = out_tready || !out_valid_r;
  assign in_tready = adv && rst_n;

  // --------------------------------------------------------------------------
  // Stage 1: year terms, reciprocal products, month table, leap seconds
  // --------------------------------------------------------------------------
  logic                     v1_r;
  logic                     bad1_r, bad1_nxt;
  logic signed [DCNT_W-1:0] p365_r, p365_nxt;
  logic [12:0]              q4_r, q4_nxt;          // (year+399)/4
  logic [11:0]              y2_r;                  // year/4
  logic [9:0]               y4_r;                  // year/16
  logic [3:0]               ylo_r;
  logic [PRD_W-1:0]         pq100_r, pq100_nxt;
  logic [PRD_W-1:0]         pq400_r, pq400_nxt;
  logic [PRD_W-1:0]         py100_r, py100_nxt;
  logic [PRD_W-1:0]         py400_r, py400_nxt;
  logic [MSTRT_W-1:0]       mst1_r;
  logic                     mar1_r;
  logic [DAY_W-1:0]         dy1_r;
  logic [SOD_W-1:0]         sod1_r, sod1_nxt;
  logic [LCNT_W-1:0]        lc1_r;

  logic signed [YEAR_W:0]   yprev;                 // year-1, may be -1
  logic [YEAR_W:0]          yq;                    // year+399

  always_comb begin
    yprev     = $signed({1'b0, yr}) - (YEAR_W+1)'(1);
    yq        = (YEAR_W+1)'(yr) + (YEAR_W+1)'(QUAD_OFS);
    q4_nxt    = yq[YEAR_W:2];
    p365_nxt  = DCNT_W'(yprev) * DCNT_W'(DAYS_PER_YR);
    pq100_nxt = PRD_W'(yq[YEAR_W:2]) * PRD_W'(RECIP25);
    pq400_nxt = PRD_W'(yq[YEAR_W:4]) * PRD_W'(RECIP25);
    py100_nxt = PRD_W'(yr[YEAR_W-1:2]) * PRD_W'(RECIP25);
    py400_nxt = PRD_W'(yr[YEAR_W-1:4]) * PRD_W'(RECIP25);
    bad1_nxt  = (mo < MON_JAN) || (mo > MON_DEC);
    sod1_nxt  = SOD_W'(hr) * SOD_W'(SEC_PER_HOUR) + SOD_W'(mi) * SOD_W'(SEC_PER_MIN)
              + SOD_W'(se);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
    if (adv) begin
      bad1_r  <= bad1_nxt;
      p365_r  <= p365_nxt;
      q4_r    <= q4_nxt;
      y2_r    <= yr[YEAR_W-1:2];
      y4_r    <= yr[YEAR_W-1:4];
      ylo_r   <= yr[3:0];
      pq100_r <= pq100_nxt;
      pq400_r <= pq400_nxt;
      py100_r <= py100_nxt;
      py400_r <= py400_nxt;
      mst1_r  <= month_start(mo);
      mar1_r  <= (mo >= MON_MAR);
      dy1_r   <= dy;
      sod1_r  <= sod1_nxt;
      lc1_r   <= leap_count(yr, mo, dy, hr, mi, se);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: quotients, leap-year test, day count, second of day
  // --------------------------------------------------------------------------
  logic                     v2_r;
  logic                     bad2_r;
  logic signed [DCNT_W-1:0] days2_r, days2_nxt;
  logic [SOD_W-1:0]         sod2_r, sod2_nxt;

  logic [7:0]  q100, y100;
  logic [5:0]  q400, y400;
  logic [11:0] y100x;
  logic [9:0]  y400x;
  logic        leap_yr;

  always_comb begin
    q100  = pq100_r[RECIP_SH+7:RECIP_SH];
    q400  = pq400_r[RECIP_SH+5:RECIP_SH];
    y100  = py100_r[RECIP_SH+7:RECIP_SH];
    y400  = py400_r[RECIP_SH+5:RECIP_SH];
    y100x = 12'(y100 * 12'(DIV25));
    y400x = 10'(y400 * 10'(DIV25));
    // divisible by 4, and not by 100 unless by 400
    leap_yr = (ylo_r[1:0] == 2'd0) &&
              ((y2_r != y100x) || ((ylo_r[3:2] == 2'd0) && (y4_r == y400x)));
    days2_nxt = p365_r
              + $signed(DCNT_W'(q4_r)) - $signed(DCNT_W'(q100)) + $signed(DCNT_W'(q400))
              + DCNT_W'(DAY_BIAS)
              + $signed(DCNT_W'(mst1_r)) + $signed(DCNT_W'(dy1_r))
              + $signed(DCNT_W'(leap_yr && mar1_r));
    sod2_nxt  = sod1_r + SOD_W'(lc1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      bad2_r  <= bad1_r;
      days2_r <= days2_nxt;
      sod2_r  <= sod2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: days to seconds (wraps modulo 2^39)
  // --------------------------------------------------------------------------
  logic                      v3_r;
  logic                      bad3_r;
  logic signed [EPOCH_W-1:0] dsec3_r, dsec3_nxt;
  logic [SOD_W-1:0]          sod3_r;

  assign dsec3_nxt = EPOCH_W'(days2_r) * $signed(EPOCH_W'(SEC_PER_DAY));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      bad3_r  <= bad2_r;
      dsec3_r <= dsec3_nxt;
      sod3_r  <= sod2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: final sum into the output register; bad month forces zero
  // --------------------------------------------------------------------------
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               bad_r;

  assign epoch_nxt = bad3_r ? '0 : EPOCH_W'(dsec3_r) + EPOCH_W'(sod3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r;
    end
    if (adv) begin
      epoch_r <= epoch_nxt;
      bad_r   <= bad3_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(epoch_r);
  assign out_tuser  = OUT_TUSER_W'(bad_r);

endmodule

FILE: hw/rtl/c2es_chk.sv
// ----------------------------------------------------------------------------
// c2es_chk: port-level checks for calendar_to_epoch_seconds
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module c2es_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [c2es_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [c2es_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [c2es_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import c2es_pkg::*;

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A held result stalls the input side in the same cycle
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output is stalled");

  // A bad month always comes with a zero result and a clean pad bit
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("bad month with nonzero result");

  // Protocol: a stalled result stays valid and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled output changed");

  // Protocol: pad bit above the result stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1] == 1'b0))
    else $error("output pad bit set");

endmodule

bind calendar_to_epoch_seconds c2es_chk u_c2es_chk (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream-level check of calendar_to_epoch_seconds
// Drives broken-down Gregorian stamps into the converter, predicts epoch
// seconds (leap seconds included) and the bad-month flag for every accepted
// stamp, and compares each output transfer against the oldest prediction.
// Both channels idle at random in the first two of three phases.
// ----------------------------------------------------------------------------

// Holds the predicted conversions in arrival order and checks each result.
class epoch_ledger;

  typedef struct packed {
    logic [c2es_pkg::EPOCH_W-1:0] epoch;
    logic                         bad_month;
  } epoch_result_t;

  localparam int EPOCH_DAYS_BEFORE_1970 = 719162;
  localparam int CUM_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  localparam longint unsigned LEAP_KEYS [5] = '{
    64'd20060101085959, 64'd20090101085959, 64'd20120701085959,
    64'd20150701085959, 64'd20170101085959
  };

  epoch_result_t pending_epochs[$];
  int            mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Convert one packed stamp to its expected result.
  function epoch_result_t civil_to_epoch(logic [c2es_pkg::IN_TDATA_W-1:0] w);
    longint          yr, mo, dy, hr, mi, se, p, days, total;
    longint unsigned key;
    bit              leap;
    epoch_result_t   r;
    yr = w[c2es_pkg::YEAR_LSB   +: c2es_pkg::YEAR_W];
    mo = w[c2es_pkg::MONTH_LSB  +: c2es_pkg::MONTH_W];
    dy = w[c2es_pkg::DAY_LSB    +: c2es_pkg::DAY_W];
    hr = w[c2es_pkg::HOUR_LSB   +: c2es_pkg::HOUR_W];
    mi = w[c2es_pkg::MINUTE_LSB +: c2es_pkg::MINUTE_W];
    se = w[c2es_pkg::SECOND_LSB +: c2es_pkg::SECOND_W];
    if (mo < c2es_pkg::MON_JAN || mo > c2es_pkg::MON_DEC) begin
      r.epoch     = '0;
      r.bad_month = 1'b1;
      return r;
    end
    // year zero is the proleptic leap year before year one
    if (yr == 0) begin
      days = -366;
    end else begin
      p    = yr - 1;
      days = p * 365 + p / 4 - p / 100 + p / 400;
    end
    leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    days = days - EPOCH_DAYS_BEFORE_1970 + CUM_DAYS[mo - 1] + dy - 1;
    if (leap && mo >= c2es_pkg::MON_MAR) days = days + 1;
    total = days * 86400 + hr * 3600 + mi * 60 + se;
    key = longint'(yr) * 64'd10000000000 + longint'(mo) * 64'd100000000
        + longint'(dy) * 64'd1000000 + longint'(hr) * 64'd10000
        + longint'(mi) * 64'd100 + longint'(se);
    foreach (LEAP_KEYS[i]) begin
      if (LEAP_KEYS[i] < key) total = total + 1;
    end
    r.epoch     = total[c2es_pkg::EPOCH_W-1:0];
    r.bad_month = 1'b0;
    return r;
  endfunction

  function void note_stamp(logic [c2es_pkg::IN_TDATA_W-1:0] w);
    pending_epochs = {pending_epochs, civil_to_epoch(w)};
  endfunction

  function void check_epoch(logic [c2es_pkg::OUT_TDATA_W-1:0] tdata,
                            logic [c2es_pkg::OUT_TUSER_W-1:0] tuser);
    epoch_result_t want;
    logic [c2es_pkg::EPOCH_W-1:0] got_epoch;
    got_epoch = tdata[c2es_pkg::EPOCH_W-1:0];
    if (pending_epochs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: epoch %0d bad_month %0b",
                 $signed(got_epoch), tuser[0]);
      return;
    end
    want = pending_epochs.pop_front();
    if (got_epoch !== want.epoch || tuser[0] !== want.bad_month) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: epoch exp %0d got %0d, bad_month exp %0b got %0b",
                 $signed(want.epoch), $signed(got_epoch), want.bad_month, tuser[0]);
    end
  endfunction

  function int outstanding();
    return pending_epochs.size();
  endfunction

  function bit failed();
    return (mismatches != 0) || (pending_epochs.size() != 0);
  endfunction

endclass

module tb;
  import c2es_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEMS_PHASE  = 580;
  localparam int DRAIN_CYCLES = 8;   // four-stage pipeline plus margin

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [c2es_pkg::IN_TDATA_W-1:0]   in_tdata;
  logic                              out_tvalid;
  logic                              out_tready;
  logic [c2es_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic [c2es_pkg::OUT_TUSER_W-1:0]  out_tuser;

  epoch_ledger ledger;
  int          gap_pct;    // chance per cycle that the sender holds off
  int          stall_pct;  // chance per cycle that the receiver stalls
  int          cycles;

  calendar_to_epoch_seconds dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: end the run if the pipeline never drains.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("calendar_to_epoch_seconds test failed");
      $finish;
    end
  end

  // Receiver: pick tready at each falling edge, check every output transfer
  // at the rising edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_epoch(out_tdata, out_tuser);
  end

  // Pack one stamp with year in the lowest bits.
  function automatic logic [c2es_pkg::IN_TDATA_W-1:0] stamp(
    logic [c2es_pkg::YEAR_W-1:0]   yr,
    logic [c2es_pkg::MONTH_W-1:0]  mo,
    logic [c2es_pkg::DAY_W-1:0]    dy,
    logic [c2es_pkg::HOUR_W-1:0]   hr,
    logic [c2es_pkg::MINUTE_W-1:0] mi,
    logic [c2es_pkg::SECOND_W-1:0] se
  );
    return {se, mi, hr, dy, mo, yr};
  endfunction

  // Offer one stamp; hold it until the transfer completes, then note it.
  task automatic send_stamp(input logic [c2es_pkg::IN_TDATA_W-1:0] w);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = w;
    do @(posedge clk); while (!in_tready);
    ledger.note_stamp(w);
    @(negedge clk);
  endtask

  // Random stamp: mostly well-formed dates, some near leap-second
  // instants, the rest raw bits.
  task automatic send_random_stamp();
    logic [c2es_pkg::YEAR_W-1:0]   yr;
    logic [c2es_pkg::MONTH_W-1:0]  mo;
    logic [c2es_pkg::DAY_W-1:0]    dy;
    logic [c2es_pkg::HOUR_W-1:0]   hr;
    logic [c2es_pkg::MINUTE_W-1:0] mi;
    logic [c2es_pkg::SECOND_W-1:0] se;
    int                            pick;
    int                            i;
    logic [63:0]                   raw;
    pick = $urandom_range(99);
    if (pick < 60) begin
      yr = YEAR_W'(($urandom_range(3) == 0) ? $urandom_range(1900, 2100)
                                            : $urandom_range(1, 9999));
      mo = MONTH_W'($urandom_range(12, 1));
      dy = DAY_W'($urandom_range(31, 1));
      hr = HOUR_W'($urandom_range(23));
      mi = MINUTE_W'($urandom_range(59));
      se = SECOND_W'($urandom_range(60));
      send_stamp(stamp(yr, mo, dy, hr, mi, se));
    end else if (pick < 80) begin
      // start on a leap instant and nudge one field across it
      i  = $urandom_range(c2es_pkg::NUM_LEAP - 1);
      yr = c2es_pkg::LS_YEAR[i];
      mo = c2es_pkg::LS_MONTH[i];
      dy = c2es_pkg::LS_DAY;
      hr = c2es_pkg::LS_HOUR;
      mi = c2es_pkg::LS_MINUTE;
      se = c2es_pkg::LS_SECOND;
      case ($urandom_range(5))
        0: se = SECOND_W'($urandom_range(63, 57));
        1: mi = MINUTE_W'($urandom_range(63, 57));
        2: hr = HOUR_W'($urandom_range(9, 7));
        3: dy = DAY_W'($urandom_range(2, 0));
        4: mo = mo + MONTH_W'(1);
        default: yr = YEAR_W'(yr - 1 + $urandom_range(2));
      endcase
      send_stamp(stamp(yr, mo, dy, hr, mi, se));
    end else begin
      raw = {$urandom, $urandom};
      send_stamp(raw[c2es_pkg::IN_TDATA_W-1:0]);
    end
  endtask

  initial begin
    int n;
    ledger     = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    gap_pct    = 20;
    stall_pct  = 65;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: epoch origin and its neighbor, range ends, bad months.
    send_stamp(stamp(14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
    send_stamp(stamp(14'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
    send_stamp(stamp(14'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
    send_stamp(stamp(14'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
    send_stamp(stamp(14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd60));
    send_stamp(stamp('1, 4'd12, '1, '1, '1, '1));
    send_stamp(stamp('1, 4'd0, '1, '1, '1, '1));
    send_stamp(stamp(14'd2020, 4'd13, 5'd5, 5'd10, 6'd10, 6'd10));
    send_stamp('1);
    // Leap-year rules around the end of February, and day zero.
    send_stamp(stamp(14'd2000, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0));
    send_stamp(stamp(14'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
    send_stamp(stamp(14'd1900, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
    send_stamp(stamp(14'd2024, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
    send_stamp(stamp(14'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
    send_stamp(stamp(14'd1970, 4'd3, 5'd0, 5'd0, 6'd0, 6'd0));
    // Each leap instant itself does not count; one second later does.
    for (int i = 0; i < c2es_pkg::NUM_LEAP; i++) begin
      send_stamp(stamp(c2es_pkg::LS_YEAR[i], c2es_pkg::LS_MONTH[i], c2es_pkg::LS_DAY,
                       c2es_pkg::LS_HOUR, c2es_pkg::LS_MINUTE, c2es_pkg::LS_SECOND));
      send_stamp(stamp(c2es_pkg::LS_YEAR[i], c2es_pkg::LS_MONTH[i], c2es_pkg::LS_DAY,
                       c2es_pkg::LS_HOUR, c2es_pkg::LS_MINUTE,
                       c2es_pkg::LS_SECOND + SECOND_W'(1)));
    end

    // Random: sender sparse gaps with heavy stalls, then the reverse,
    // then full rate on both sides.
    for (n = 0; n < ITEMS_PHASE; n++) send_random_stamp();
    gap_pct   = 65;
    stall_pct = 20;
    for (n = 0; n < ITEMS_PHASE; n++) send_random_stamp();
    gap_pct   = 0;
    stall_pct = 0;
    for (n = 0; n < ITEMS_PHASE; n++) send_random_stamp();
    in_tvalid = 1'b0;

    // Drain the pipeline, then wait out the drain margin to show strays.
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!ledger.failed()) begin
      $display("calendar_to_epoch_seconds test passed");
    end else begin
      $display("calendar_to_epoch_seconds test failed");
    end
    $finish;
  end

endmodule
